FILE: src/pspec_pkg.sv
`timescale 1ns / 1ps

package pspec_pkg;

  // default counter width for field width and precision
  localparam int DEF_COUNT_BITS = 16;

  // digit conversion
  localparam logic [7:0] DIGIT_BASE = 8'h30;
  localparam int         RADIX      = 10;

  // characters the parser recognizes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_J     = 8'h6A;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_CAP_L = 8'h4C;

  // length modifier codes
  localparam logic [3:0] LEN_INT     = 4'd0;
  localparam logic [3:0] LEN_CHAR    = 4'd1;
  localparam logic [3:0] LEN_SHORT   = 4'd2;
  localparam logic [3:0] LEN_LONG    = 4'd3;
  localparam logic [3:0] LEN_LLONG   = 4'd4;
  localparam logic [3:0] LEN_INTMAX  = 4'd5;
  localparam logic [3:0] LEN_SIZE    = 4'd6;
  localparam logic [3:0] LEN_PTRDIFF = 4'd7;
  localparam logic [3:0] LEN_LDOUBLE = 4'd8;

  // parse phases
  typedef enum logic [2:0] {
    PH_FLAGS  = 3'd0,
    PH_WDIG   = 3'd1,
    PH_WDONE  = 3'd2,
    PH_PSTART = 3'd3,
    PH_PDIG   = 3'd4,
    PH_PDONE  = 3'd5,
    PH_LEN    = 3'd6
  } phase_t;

  // flags collected so far
  typedef struct packed {
    logic lj;
    logic sign;
    logic space;
    logic alt;
    logic zero;
    logic wg;
    logic pg;
  } flags_t;

  // parser control state
  typedef struct packed {
    phase_t     phase;
    flags_t     flags;
    logic       sat;
    logic [3:0] len;
  } ctl_t;

  // one finished spec
  typedef struct packed {
    logic        left_justify;
    logic        show_sign;
    logic        space_sign;
    logic        alt_form;
    logic        zero_pad;
    logic        width_given;
    logic [15:0] min_width;
    logic        prec_given;
    logic [15:0] precision;
    logic [3:0]  length_code;
    logic [7:0]  end_char;
    logic        saturated;
  } res_t;

  // length modifier letter to code, int when not a modifier
  function automatic logic [3:0] length_of(input logic [7:0] c);
    logic [3:0] lc;
    unique case (c)
      CH_H:     lc = LEN_SHORT;
      CH_L:     lc = LEN_LONG;
      CH_J:     lc = LEN_INTMAX;
      CH_Z:     lc = LEN_SIZE;
      CH_T:     lc = LEN_PTRDIFF;
      CH_CAP_L: lc = LEN_LDOUBLE;
      default:  lc = LEN_INT;
    endcase
    return lc;
  endfunction

endpackage

FILE: src/pspec_step.sv
`timescale 1ns / 1ps

module pspec_step #(
  parameter int COUNT_BITS = pspec_pkg::DEF_COUNT_BITS
) (
  input  logic [7:0]            ch,
  input  logic signed [31:0]    star_value,
  input  pspec_pkg::ctl_t       ctl,
  input  logic [COUNT_BITS-1:0] width_acc,
  input  logic [COUNT_BITS-1:0] prec_acc,
  output pspec_pkg::ctl_t       ctl_next,
  output logic [COUNT_BITS-1:0] width_next,
  output logic [COUNT_BITS-1:0] prec_next,
  output logic                  emit,
  output pspec_pkg::res_t       res
);

  localparam int SumW = COUNT_BITS + 4;

  logic                  is_digit;
  logic [3:0]            dval;
  logic [SumW-1:0]       wd_sum;
  logic [SumW-1:0]       pd_sum;
  logic                  wd_sat;
  logic                  pd_sat;
  logic [COUNT_BITS-1:0] wd_val;
  logic [COUNT_BITS-1:0] pd_val;
  logic                  star_neg;
  logic [31:0]           star_mag;
  logic                  star_sat;
  logic [COUNT_BITS-1:0] star_val;
  logic [3:0]            lc;
  logic                  taken;

  // digit classification
  assign is_digit = (ch >= pspec_pkg::CH_ZERO) && (ch <= pspec_pkg::CH_NINE);
  assign dval     = 4'(ch - pspec_pkg::DIGIT_BASE);

  // multiply-by-ten accumulate with saturation
  assign wd_sum = SumW'(SumW'(width_acc) * SumW'(pspec_pkg::RADIX) + SumW'(dval));
  assign pd_sum = SumW'(SumW'(prec_acc) * SumW'(pspec_pkg::RADIX) + SumW'(dval));
  assign wd_sat = |wd_sum[SumW-1:COUNT_BITS];
  assign pd_sat = |pd_sum[SumW-1:COUNT_BITS];
  assign wd_val = wd_sat ? '1 : wd_sum[COUNT_BITS-1:0];
  assign pd_val = pd_sat ? '1 : pd_sum[COUNT_BITS-1:0];

  // star argument magnitude, clamped to the counter range
  assign star_neg = star_value[31];
  assign star_mag = star_neg ? 32'(-star_value) : 32'(star_value);
  assign star_sat = |(star_mag >> COUNT_BITS);
  assign star_val = star_sat ? '1 : star_mag[COUNT_BITS-1:0];

  assign lc = pspec_pkg::length_of(ch);

  // next state decode
  always_comb begin
    ctl_next   = ctl;
    width_next = width_acc;
    prec_next  = prec_acc;
    taken      = 1'b0;

    unique case (ctl.phase)
      pspec_pkg::PH_FLAGS: begin
        taken = 1'b1;
        if (ch == pspec_pkg::CH_MINUS) begin
          ctl_next.flags.lj = 1'b1;
        end else if (ch == pspec_pkg::CH_PLUS) begin
          ctl_next.flags.sign = 1'b1;
        end else if (ch == pspec_pkg::CH_SPACE) begin
          ctl_next.flags.space = 1'b1;
        end else if (ch == pspec_pkg::CH_HASH) begin
          ctl_next.flags.alt = 1'b1;
        end else if (ch == pspec_pkg::CH_ZERO) begin
          ctl_next.flags.zero = 1'b1;
        end else if (ch == pspec_pkg::CH_STAR) begin
          ctl_next.flags.wg = 1'b1;
          if (star_neg) begin
            ctl_next.flags.lj = 1'b1;
          end
          width_next     = star_val;
          ctl_next.sat   = ctl.sat | star_sat;
          ctl_next.phase = pspec_pkg::PH_WDONE;
        end else if (is_digit) begin
          ctl_next.flags.wg = 1'b1;
          width_next     = wd_val;
          ctl_next.sat   = ctl.sat | wd_sat;
          ctl_next.phase = pspec_pkg::PH_WDIG;
        end else if (ch == pspec_pkg::CH_DOT) begin
          ctl_next.flags.pg   = 1'b1;
          ctl_next.flags.zero = 1'b0;
          prec_next      = '0;
          ctl_next.phase = pspec_pkg::PH_PSTART;
        end else begin
          taken = 1'b0;
        end
      end
      pspec_pkg::PH_WDIG: begin
        if (is_digit) begin
          width_next   = wd_val;
          ctl_next.sat = ctl.sat | wd_sat;
          taken        = 1'b1;
        end else if (ch == pspec_pkg::CH_DOT) begin
          ctl_next.flags.pg   = 1'b1;
          ctl_next.flags.zero = 1'b0;
          prec_next      = '0;
          ctl_next.phase = pspec_pkg::PH_PSTART;
          taken          = 1'b1;
        end
      end
      pspec_pkg::PH_WDONE: begin
        if (ch == pspec_pkg::CH_DOT) begin
          ctl_next.flags.pg   = 1'b1;
          ctl_next.flags.zero = 1'b0;
          prec_next      = '0;
          ctl_next.phase = pspec_pkg::PH_PSTART;
          taken          = 1'b1;
        end
      end
      pspec_pkg::PH_PSTART: begin
        if (ch == pspec_pkg::CH_STAR) begin
          // negative star precision drops the precision
          if (star_neg) begin
            ctl_next.flags.pg = 1'b0;
          end else begin
            prec_next    = star_val;
            ctl_next.sat = ctl.sat | star_sat;
          end
          ctl_next.phase = pspec_pkg::PH_PDONE;
          taken          = 1'b1;
        end else if (is_digit) begin
          prec_next      = pd_val;
          ctl_next.sat   = ctl.sat | pd_sat;
          ctl_next.phase = pspec_pkg::PH_PDIG;
          taken          = 1'b1;
        end
      end
      pspec_pkg::PH_PDIG: begin
        if (is_digit) begin
          prec_next    = pd_val;
          ctl_next.sat = ctl.sat | pd_sat;
          taken        = 1'b1;
        end
      end
      pspec_pkg::PH_LEN: begin
        // hh and ll
        if (ctl.len == pspec_pkg::LEN_SHORT && ch == pspec_pkg::CH_H) begin
          ctl_next.len = pspec_pkg::LEN_CHAR;
          taken        = 1'b1;
        end else if (ctl.len == pspec_pkg::LEN_LONG && ch == pspec_pkg::CH_L) begin
          ctl_next.len = pspec_pkg::LEN_LLONG;
          taken        = 1'b1;
        end
      end
      default: begin
        taken = 1'b0;
      end
    endcase

    // length modifier may start from any phase before it
    if (!taken && ctl.phase != pspec_pkg::PH_LEN && lc != pspec_pkg::LEN_INT) begin
      ctl_next.len   = lc;
      ctl_next.phase = pspec_pkg::PH_LEN;
      taken          = 1'b1;
    end

    // spec ends: clear everything for the next one
    if (!taken) begin
      ctl_next.phase = pspec_pkg::PH_FLAGS;
      ctl_next.flags = '0;
      ctl_next.sat   = 1'b0;
      ctl_next.len   = pspec_pkg::LEN_INT;
      width_next     = '0;
      prec_next      = '0;
    end
  end

  assign emit = !taken;

  // result fields from the state the ending character finds
  always_comb begin
    res.left_justify = ctl.flags.lj;
    res.show_sign    = ctl.flags.sign;
    res.space_sign   = ctl.flags.space & ~ctl.flags.sign;
    res.alt_form     = ctl.flags.alt;
    res.zero_pad     = ctl.flags.zero;
    res.width_given  = ctl.flags.wg;
    res.min_width    = 16'(width_acc);
    res.prec_given   = ctl.flags.pg;
    res.precision    = ctl.flags.pg ? 16'(prec_acc) : 16'd0;
    res.length_code  = ctl.len;
    res.end_char     = ch;
    res.saturated    = ctl.sat;
  end

endmodule

FILE: src/printf_spec_parser.sv
`timescale 1ns / 1ps

// channel | signals                          | item
// --------+----------------------------------+-----------------------------------------
// in      | in_valid, in_ready               | ch, star_value
// out     | out_valid, out_ready             | spec fields, zero or one per in item
//
// One character per cycle: an item goes into the input register, then one pass of
// decode and multiply-by-ten accumulate updates the parse state and loads the result
// register; out_valid rises when the ending character moves from the input register into the result register.
// Reset clears the parse state to the flags phase and empties both registers.
// A stalled result only blocks characters that end a spec; the rest keep flowing.

module printf_spec_parser #(
  parameter int COUNT_BITS = pspec_pkg::DEF_COUNT_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         ch,
  input  logic signed [31:0] star_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               left_justify,
  output logic               show_sign,
  output logic               space_sign,
  output logic               alt_form,
  output logic               zero_pad,
  output logic               width_given,
  output logic [15:0]        min_width,
  output logic               prec_given,
  output logic [15:0]        precision,
  output logic [3:0]         length_code,
  output logic [7:0]         end_char,
  output logic               saturated
);

  logic                  item_valid;
  logic [7:0]            item_ch;
  logic signed [31:0]    item_star;
  pspec_pkg::ctl_t       ctl;
  pspec_pkg::ctl_t       ctl_next;
  logic [COUNT_BITS-1:0] width_acc;
  logic [COUNT_BITS-1:0] width_acc_next;
  logic [COUNT_BITS-1:0] prec_acc;
  logic [COUNT_BITS-1:0] prec_acc_next;
  logic                  emit;
  logic                  advance;
  pspec_pkg::res_t       res;

  // parse step
  pspec_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .ch         (item_ch),
    .star_value (item_star),
    .ctl        (ctl),
    .width_acc  (width_acc),
    .prec_acc   (prec_acc),
    .ctl_next   (ctl_next),
    .width_next (width_acc_next),
    .prec_next  (prec_acc_next),
    .emit       (emit),
    .res        (res)
  );

  // held item moves on unless it ends a spec while the result register is full and out_ready is low
  assign advance  = item_valid && (!emit || !out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_ch   <= ch;
      item_star <= star_value;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl       <= '{phase: pspec_pkg::PH_FLAGS, flags: '0, sat: 1'b0,
                     len: pspec_pkg::LEN_INT};
      width_acc <= '0;
      prec_acc  <= '0;
    end else if (advance) begin
      ctl       <= ctl_next;
      width_acc <= width_acc_next;
      prec_acc  <= prec_acc_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      left_justify <= res.left_justify;
      show_sign    <= res.show_sign;
      space_sign   <= res.space_sign;
      alt_form     <= res.alt_form;
      zero_pad     <= res.zero_pad;
      width_given  <= res.width_given;
      min_width    <= res.min_width;
      prec_given   <= res.prec_given;
      precision    <= res.precision;
      length_code  <= res.length_code;
      end_char     <= res.end_char;
      saturated    <= res.saturated;
    end
  end

endmodule
